@@ hdl/tvp_pkg.sv @@
package tvp_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int STEP_W         = 16;
  localparam int MODEL_W        = 64;
  localparam int SQW            = 32;
  localparam int SQ_ITER        = 32;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ACCEL,
    PH_CRUISE,
    PH_DECEL
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVQ,
    ST_MULR,
    ST_MULS,
    ST_SQRT,
    ST_DIVT,
    ST_DIVC,
    ST_FIN,
    ST_TDV,
    ST_TVEL,
    ST_TMUL,
    ST_TOUT
  } state_e;

  // dividend width of the shifted divisions
  function automatic int dw_f(input int w, input int f);
    return (w + f > MODEL_W) ? MODEL_W : w + f;
  endfunction

  // width of the shared datapath, always above the model word
  function automatic int prw_f(input int w, input int f);
    int p;
    p = dw_f(w, f) + w - 1;
    return (p > MODEL_W + 1) ? p : MODEL_W + 1;
  endfunction

endpackage

@@ hdl/tvp_arith.sv @@
module tvp_arith #(
  parameter int W = tvp_pkg::WORD_WIDTH_DEF,
  parameter int F = tvp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tvp_pkg::arith_req_t               req_i,
  input  logic [tvp_pkg::prw_f(W, F)-1:0]   opa_i,
  input  logic [tvp_pkg::prw_f(W, F)-1:0]   opb_i,
  output logic                              done_o,
  output logic [tvp_pkg::prw_f(W, F)-1:0]   res_o
);
  import tvp_pkg::*;

  localparam int DW   = dw_f(W, F);
  localparam int PRW  = prw_f(W, F);
  localparam int NMAX = (DW > SQ_ITER) ? DW : SQ_ITER;
  localparam int CW   = $clog2(NMAX + 1);

  logic            busy_q, done_q, ge_q;
  arith_op_e       op_q;
  logic [CW-1:0]   cnt_q;
  logic [1:0]      sq_ph_q;
  logic [PRW-1:0]  acc_q, opa_q, opb_q, tmp_q;
  logic [PRW-1:0]  add_a, add_b, add_bx;
  logic            sub;
  logic [PRW:0]    sum;
  logic            ge, step_end, last;

  // one adder / subtractor serves all three operations
  always_comb begin
    add_a = '0;
    add_b = '0;
    sub   = 1'b0;
    unique case (op_q)
      OP_MUL: begin
        add_a = acc_q;
        add_b = opb_q[0] ? opa_q : '0;
      end
      OP_DIV: begin
        add_a = {acc_q[PRW-2:0], opa_q[DW-1]};
        add_b = opb_q;
        sub   = 1'b1;
      end
      OP_SQRT: begin
        case (sq_ph_q)
          2'd0: begin
            add_a = opa_q;
            add_b = opb_q;
          end
          2'd1: begin
            add_a = acc_q;
            add_b = tmp_q;
            sub   = 1'b1;
          end
          default: begin
            add_a = opa_q >> 1;
            add_b = ge_q ? opb_q : '0;
          end
        endcase
      end
      default: ;
    endcase
    add_bx   = sub ? ~add_b : add_b;
    sum      = {1'b0, add_a} + {1'b0, add_bx} + (PRW + 1)'(sub);
    ge       = sum[PRW];
    step_end = (op_q != OP_SQRT) || (sq_ph_q == 2'd2);
    last     = (cnt_q == CW'(1)) && step_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      op_q    <= OP_MUL;
      cnt_q   <= '0;
      sq_ph_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (req_i.start) begin
          busy_q  <= 1'b1;
          op_q    <= req_i.op;
          sq_ph_q <= '0;
          unique case (req_i.op)
            OP_MUL:  cnt_q <= CW'(W - 1);
            OP_DIV:  cnt_q <= CW'(DW);
            OP_SQRT: cnt_q <= CW'(SQ_ITER);
            default: cnt_q <= CW'(1);
          endcase
        end
      end else begin
        if (op_q == OP_SQRT) begin
          sq_ph_q <= (sq_ph_q == 2'd2) ? 2'd0 : sq_ph_q + 2'd1;
        end
        if (step_end) begin
          cnt_q <= cnt_q - CW'(1);
        end
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (req_i.start) begin
        acc_q <= (req_i.op == OP_SQRT) ? opa_i : '0;
        opa_q <= (req_i.op == OP_SQRT) ? '0 : opa_i;
        opb_q <= (req_i.op == OP_SQRT) ? (PRW'(1) << (MODEL_W - 2)) : opb_i;
      end
    end else begin
      unique case (op_q)
        OP_MUL: begin
          acc_q <= sum[PRW-1:0];
          opa_q <= opa_q << 1;
          opb_q <= opb_q >> 1;
        end
        OP_DIV: begin
          acc_q <= ge ? sum[PRW-1:0] : {acc_q[PRW-2:0], opa_q[DW-1]};
          opa_q <= {opa_q[PRW-2:0], ge};
        end
        OP_SQRT: begin
          case (sq_ph_q)
            2'd0: tmp_q <= sum[PRW-1:0];
            2'd1: begin
              ge_q <= ge;
              if (ge) begin
                acc_q <= sum[PRW-1:0];
              end
            end
            default: begin
              opa_q <= sum[PRW-1:0];
              opb_q <= opb_q >> 2;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_MUL) ? acc_q : opa_q;

endmodule

@@ hdl/trapezoid_velocity_profile_gen_core.sv @@
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_ready_o mode, target, limits, time step
// out      output     out_valid_o/out_ready_i velocity, phase, done, times, distance
//
// One request at a time. A tick runs ST_TDV, ST_TVEL, ST_TMUL, ST_TOUT (ST_TOUT alone
// while no profile runs). A start runs divisions, multiplies and, for a triangle, a square
// root through the shared adder: DIVQ, MULR, DIVC for a trapezoid, DIVQ, MULR, MULS,
// SQRT, DIVT for a triangle, DIVQ, MULR for a zero velocity limit, none for zero accel.
// Results wait in an output register; a full register stalls the last step.
// Reset clears the whole profile state.
module trapezoid_velocity_profile_gen_core #(
  parameter int WORD_WIDTH = tvp_pkg::WORD_WIDTH_DEF,
  parameter int FRAC_BITS  = tvp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic signed [WORD_WIDTH-1:0]      target_distance_i,
  input  logic [WORD_WIDTH-2:0]             velocity_limit_i,
  input  logic [WORD_WIDTH-2:0]             accel_limit_i,
  input  logic [tvp_pkg::STEP_W-1:0]        time_step_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [WORD_WIDTH-1:0]      velocity_ref_o,
  output logic [1:0]                        phase_o,
  output logic                              profile_done_o,
  output logic [WORD_WIDTH-2:0]             accel_time_o,
  output logic [WORD_WIDTH-2:0]             cruise_time_o,
  output logic [WORD_WIDTH-2:0]             decel_time_o,
  output logic signed [WORD_WIDTH-1:0]      open_loop_distance_o
);
  import tvp_pkg::*;

  localparam int W    = WORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = dw_f(W, F);
  localparam int PRW  = prw_f(W, F);
  localparam int PKW  = (W - 1 > SQW) ? W - 1 : SQW;
  localparam int VW   = (W + 9 > PKW + 2) ? W + 9 : PKW + 2;
  localparam int DVW  = W - 1 + STEP_W - F;
  localparam int PDW  = W + STEP_W + 1;
  localparam int DSW  = PDW + 1;

  state_e                 state_q, state_d;
  logic                   issued_q, issued_d;
  arith_req_t             req;
  logic [PRW-1:0]         opa, opb, ares;
  logic                   adone;

  // profile state
  logic                   active_q, dir_neg_q;
  logic [W-1:0]           elapsed_q;
  logic [W-2:0]           ramp_time_q, hold_time_q, ramp_accel_q;
  logic [PKW-1:0]         peak_hold_q;
  logic signed [W-1:0]    run_vel_q, run_dist_q;

  // scratch
  logic                   neg_q;
  logic [W-1:0]           mag_q, diff_q;
  logic [W-2:0]           vmax_q, amax_q;
  logic [STEP_W-1:0]      dt_q;
  logic [DW-1:0]          q_q, ta_q, tc_q;
  logic [MODEL_W-1:0]     sqx_q;
  logic [DVW-1:0]         dv_q;
  logic [W-1:0]           el_q;
  logic signed [W-1:0]    vel_q;
  phase_e                 ph_q;
  logic                   fin_q;
  logic signed [PDW-1:0]  prod_q;
  logic [PKW-1:0]         peak_q;

  // output register
  logic                   out_valid_q;
  logic signed [W-1:0]    o_vel_q, o_dist_q;
  phase_e                 o_ph_q;
  logic                   o_done_q;
  logic [W-2:0]           o_ta_q, o_tc_q;

  logic                   slot_free, accept;
  logic                   ovf, ramp_ge;
  logic [MODEL_W-1:0]     da, ramp;
  logic [W-2:0]           ta_sat, tc_sat;
  logic [W:0]             e_sum, total;
  logic [W-1:0]           rh_sum;
  logic signed [VW-1:0]   sdv, v, pk_s;
  phase_e                 ph;
  logic signed [W-1:0]    v_sat;
  logic signed [PDW-1:0]  step_d;
  logic signed [DSW-1:0]  dsum;
  logic signed [W-1:0]    d_sat;
  logic [W-2+STEP_W:0]    dv_full;

  function automatic logic [PRW-1:0] shl_f(input logic [PRW-1:0] x);
    logic [PRW-1:0] s;
    s = x << F;
    return PRW'(s[DW-1:0]);
  endfunction

  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  always_comb begin
    ovf     = |ares[PRW-1:MODEL_W];
    da      = ares[MODEL_W-1:0] >> (F + 1);
    ramp    = {da[MODEL_W-2:0], 1'b0};
    ramp_ge = ovf || (ramp >= MODEL_W'(mag_q));
    ta_sat  = (|ta_q[DW-1:W-1]) ? {(W - 1){1'b1}} : ta_q[W-2:0];
    tc_sat  = (|tc_q[DW-1:W-1]) ? {(W - 1){1'b1}} : tc_q[W-2:0];

    e_sum   = {1'b0, elapsed_q} + (W + 1)'(dt_q);
    dv_full = (W - 1 + STEP_W)'(dt_q) * (W - 1 + STEP_W)'(ramp_accel_q);
    total   = {1'b0, ramp_time_q, 1'b0} + (W + 1)'(hold_time_q);
    rh_sum  = W'(ramp_time_q) + W'(hold_time_q);
    sdv     = dir_neg_q ? -$signed(VW'(dv_q)) : $signed(VW'(dv_q));
    pk_s    = dir_neg_q ? -$signed(VW'(peak_hold_q)) : $signed(VW'(peak_hold_q));
    if ((W + 1)'(el_q) <= (W + 1)'(ramp_time_q)) begin
      v  = VW'(run_vel_q) + sdv;
      ph = PH_ACCEL;
    end else if (el_q <= rh_sum && hold_time_q != '0) begin
      v  = pk_s;
      ph = PH_CRUISE;
    end else begin
      v  = VW'(run_vel_q) - sdv;
      ph = PH_DECEL;
    end
    if (v[VW-1:W-1] == '0 || v[VW-1:W-1] == '1) begin
      v_sat = v[W-1:0];
    end else begin
      v_sat = v[VW-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    end

    step_d = prod_q >>> F;
    dsum   = DSW'(run_dist_q) + DSW'(step_d);
    if (dsum[DSW-1:W-1] == '0 || dsum[DSW-1:W-1] == '1) begin
      d_sat = dsum[W-1:0];
    end else begin
      d_sat = dsum[DSW-1] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    req.start = 1'b0;
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            state_d = (accel_limit_i == '0) ? ST_FIN : ST_DIVQ;
          end else begin
            state_d = active_q ? ST_TDV : ST_TOUT;
          end
        end
      end
      ST_DIVQ, ST_MULR, ST_MULS, ST_SQRT, ST_DIVT, ST_DIVC: begin
        req.start = !issued_q;
        case (state_q)
          ST_DIVQ: begin
            req.op = OP_DIV;
            opa    = shl_f(PRW'(vmax_q));
            opb    = PRW'(amax_q);
          end
          ST_MULR: begin
            opa = PRW'(q_q);
            opb = PRW'(vmax_q);
          end
          ST_MULS: begin
            opa = PRW'(mag_q);
            opb = PRW'(amax_q);
          end
          ST_SQRT: begin
            req.op = OP_SQRT;
            opa    = PRW'(sqx_q);
          end
          ST_DIVT: begin
            req.op = OP_DIV;
            opa    = shl_f(PRW'(peak_q));
            opb    = PRW'(amax_q);
          end
          default: begin
            req.op = OP_DIV;
            opa    = shl_f(PRW'(diff_q));
            opb    = PRW'(vmax_q);
          end
        endcase
        if (req.start) begin
          issued_d = 1'b1;
        end
        if (adone) begin
          issued_d = 1'b0;
          case (state_q)
            ST_DIVQ: state_d = ST_MULR;
            ST_MULR: begin
              if (ramp_ge) begin
                state_d = ST_MULS;
              end else begin
                state_d = (vmax_q == '0) ? ST_FIN : ST_DIVC;
              end
            end
            ST_MULS: state_d = ST_SQRT;
            ST_SQRT: state_d = ST_DIVT;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_FIN, ST_TOUT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_TDV:  state_d = ST_TVEL;
      ST_TVEL: state_d = ST_TMUL;
      ST_TMUL: state_d = ST_TOUT;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  tvp_arith #(
    .W (W),
    .F (F)
  ) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .opa_i  (opa),
    .opb_i  (opb),
    .done_o (adone),
    .res_o  (ares)
  );

  // scratch registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          neg_q  <= target_distance_i[W-1];
          mag_q  <= target_distance_i[W-1] ? -target_distance_i : target_distance_i;
          vmax_q <= velocity_limit_i;
          amax_q <= accel_limit_i;
          dt_q   <= time_step_i;
          ta_q   <= '0;
          tc_q   <= '0;
          peak_q <= '0;
        end
      end
      ST_DIVQ: if (adone) q_q <= ares[DW-1:0];
      ST_MULR: begin
        if (adone) begin
          diff_q <= mag_q - ramp[W-1:0];
          if (!ramp_ge) begin
            ta_q   <= q_q;
            tc_q   <= {{(DW - W + 1){1'b0}}, {(W - 1){1'b1}}};
            peak_q <= PKW'(vmax_q);
          end
        end
      end
      ST_MULS: if (adone) sqx_q <= ares[MODEL_W-1:0];
      ST_SQRT: if (adone) peak_q <= PKW'(ares[SQW-1:0]);
      ST_DIVT: begin
        if (adone) begin
          ta_q <= ares[DW-1:0];
          tc_q <= '0;
        end
      end
      ST_DIVC: if (adone) tc_q <= ares[DW-1:0];
      ST_TDV: begin
        el_q <= e_sum[W] ? {W{1'b1}} : e_sum[W-1:0];
        dv_q <= dv_full[W-2+STEP_W:F];
      end
      ST_TVEL: begin
        fin_q <= (W + 1)'(el_q) > total;
        vel_q <= v_sat;
        ph_q  <= ph;
      end
      ST_TMUL: prod_q <= PDW'(vel_q) * $signed({1'b0, dt_q});
      default: ;
    endcase
  end

  // profile state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      dir_neg_q    <= 1'b0;
      elapsed_q    <= '0;
      ramp_time_q  <= '0;
      hold_time_q  <= '0;
      ramp_accel_q <= '0;
      peak_hold_q  <= '0;
      run_vel_q    <= '0;
      run_dist_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_FIN && slot_free) begin
        out_valid_q  <= 1'b1;
        active_q     <= 1'b1;
        dir_neg_q    <= neg_q;
        elapsed_q    <= '0;
        ramp_time_q  <= ta_sat;
        hold_time_q  <= tc_sat;
        ramp_accel_q <= amax_q;
        peak_hold_q  <= peak_q;
        run_vel_q    <= '0;
        run_dist_q   <= '0;
      end
      if (state_q == ST_TOUT && slot_free) begin
        out_valid_q <= 1'b1;
        if (active_q) begin
          elapsed_q <= el_q;
          if (fin_q) begin
            active_q  <= 1'b0;
            run_vel_q <= '0;
          end else begin
            run_vel_q  <= vel_q;
            run_dist_q <= d_sat;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && slot_free) begin
      o_vel_q  <= '0;
      o_ph_q   <= PH_IDLE;
      o_done_q <= 1'b0;
      o_ta_q   <= ta_sat;
      o_tc_q   <= tc_sat;
      o_dist_q <= '0;
    end else if (state_q == ST_TOUT && slot_free) begin
      o_ta_q <= ramp_time_q;
      o_tc_q <= hold_time_q;
      if (!active_q) begin
        o_vel_q  <= run_vel_q;
        o_ph_q   <= PH_IDLE;
        o_done_q <= 1'b0;
        o_dist_q <= run_dist_q;
      end else if (fin_q) begin
        o_vel_q  <= '0;
        o_ph_q   <= PH_IDLE;
        o_done_q <= 1'b1;
        o_dist_q <= run_dist_q;
      end else begin
        o_vel_q  <= vel_q;
        o_ph_q   <= ph_q;
        o_done_q <= 1'b0;
        o_dist_q <= d_sat;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign velocity_ref_o       = o_vel_q;
  assign phase_o              = o_ph_q;
  assign profile_done_o       = o_done_q;
  assign accel_time_o         = o_ta_q;
  assign cruise_time_o        = o_tc_q;
  assign decel_time_o         = o_ta_q;
  assign open_loop_distance_o = o_dist_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while a request is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && profile_done_o |-> velocity_ref_o == '0 && phase_o == PH_IDLE)
    else $error("profile end with nonzero velocity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == PH_CRUISE |-> cruise_time_o != '0)
    else $error("cruise phase without cruise time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adone |-> !req.start)
    else $error("arithmetic unit restarted on completion");

endmodule

@@ dv/trapezoid_velocity_profile_gen_core_tb.sv @@
`timescale 1ns / 1ps

module trapezoid_velocity_profile_gen_core_tb;
  import tvp_pkg::*;

  localparam int W = 32;
  localparam int F = 16;
  localparam longint unsigned TMAX = (64'd1 << (W - 1)) - 1;
  localparam longint unsigned EMAX = (64'd1 << W) - 1;
  localparam longint SMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;

  typedef struct {
    logic signed [W-1:0] vel;
    phase_e              ph;
    logic                done;
    logic [W-2:0]        ta;
    logic [W-2:0]        tc;
    logic [W-2:0]        td;
    logic signed [W-1:0] distance;
  } motion_out_t;

  class profile_scoreboard;
    motion_out_t     pending_q[$];
    int              errors;
    bit              run;
    longint unsigned t_el, t_ramp, t_hold, v_peak, a_ramp;
    bit              neg_dir;
    longint          v_run, d_run;

    function new();
      errors = 0;
      run = 0; t_el = 0; t_ramp = 0; t_hold = 0; v_peak = 0; a_ramp = 0;
      neg_dir = 0; v_run = 0; d_run = 0;
    endfunction

    function longint unsigned mul_sat(longint unsigned a, longint unsigned b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:64] != 0) return '1;
      return p[63:0] >> sh;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint clamp(longint v);
      if (v > SMAX) return SMAX;
      if (v < SMIN) return SMIN;
      return v;
    endfunction

    function longint unsigned tsat(longint unsigned v);
      return (v > TMAX) ? TMAX : v;
    endfunction

    function void push(longint vel, phase_e ph, bit done);
      motion_out_t o;
      o.vel = vel[W-1:0];
      o.ph = ph;
      o.done = done;
      o.ta = t_ramp[W-2:0];
      o.tc = t_hold[W-2:0];
      o.td = t_ramp[W-2:0];
      o.distance = d_run[W-1:0];
      pending_q.push_back(o);
    endfunction

    function void note_request(bit mode, logic [W-1:0] tgt, logic [W-2:0] vl,
                               logic [W-2:0] al, logic [15:0] step);
      longint unsigned mag, vmax, amax, ta, tc, pk, q, da, rmp, dt, e, total;
      longint dv, v;
      phase_e ph;
      if (!mode) begin
        vmax = vl; amax = al;
        mag = tgt[W-1] ? ((64'd1 << W) - tgt) : tgt;
        ta = 0; tc = 0; pk = 0;
        if (amax != 0) begin
          q = (vmax << F) / amax;
          da = mul_sat(q, vmax, F + 1);
          rmp = (da > (64'hFFFF_FFFF_FFFF_FFFF / 2)) ? '1 : 2 * da;
          if (rmp >= mag) begin
            pk = root(mag * amax);
            ta = (pk << F) / amax;
            tc = 0;
          end else begin
            pk = vmax;
            ta = q;
            tc = (vmax != 0) ? ((mag - rmp) << F) / vmax : TMAX;
          end
        end
        t_ramp = tsat(ta); t_hold = tsat(tc); v_peak = pk; a_ramp = amax;
        neg_dir = tgt[W-1]; t_el = 0; v_run = 0; d_run = 0; run = 1;
        push(0, PH_IDLE, 0);
        return;
      end
      if (!run) begin
        push(v_run, PH_IDLE, 0);
        return;
      end
      dt = step;
      e = t_el + dt;
      total = 2 * t_ramp + t_hold;
      dv = longint'((dt * a_ramp) >> F);
      t_el = (e > EMAX) ? EMAX : e;
      if (t_el > total) begin
        run = 0;
        v_run = 0;
        push(0, PH_IDLE, 1);
        return;
      end
      if (neg_dir) dv = -dv;
      if (t_el <= t_ramp) begin
        v = v_run + dv; ph = PH_ACCEL;
      end else if (t_el <= t_ramp + t_hold && t_hold > 0) begin
        v = neg_dir ? -longint'(v_peak) : longint'(v_peak); ph = PH_CRUISE;
      end else begin
        v = v_run - dv; ph = PH_DECEL;
      end
      v_run = clamp(v);
      d_run = clamp(d_run + ((v_run * longint'(dt)) >>> F));
      push(v_run, ph, 0);
    endfunction

    function void check_result(motion_out_t a);
      motion_out_t x;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result vel=%0d", $time, a.vel);
        errors++;
        return;
      end
      x = pending_q.pop_front();
      if (a.vel !== x.vel) begin
        $display("%0t: velocity_ref exp %0d act %0d", $time, x.vel, a.vel); errors++;
      end
      if (a.ph !== x.ph) begin
        $display("%0t: phase exp %0d act %0d", $time, x.ph, a.ph); errors++;
      end
      if (a.done !== x.done) begin
        $display("%0t: profile_done exp %0d act %0d", $time, x.done, a.done); errors++;
      end
      if (a.ta !== x.ta) begin
        $display("%0t: accel_time exp %0d act %0d", $time, x.ta, a.ta); errors++;
      end
      if (a.tc !== x.tc) begin
        $display("%0t: cruise_time exp %0d act %0d", $time, x.tc, a.tc); errors++;
      end
      if (a.td !== x.td) begin
        $display("%0t: decel_time exp %0d act %0d", $time, x.td, a.td); errors++;
      end
      if (a.distance !== x.distance) begin
        $display("%0t: open_loop_distance exp %0d act %0d", $time, x.distance,
                 a.distance);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                in_valid_i = 0;
  logic                in_ready_o;
  logic                mode_i = 0;
  logic signed [W-1:0] target_distance_i = 0;
  logic [W-2:0]        velocity_limit_i = 0;
  logic [W-2:0]        accel_limit_i = 0;
  logic [15:0]         time_step_i = 0;
  logic                out_valid_o;
  logic                out_ready_i = 0;
  logic signed [W-1:0] velocity_ref_o;
  logic [1:0]          phase_o;
  logic                profile_done_o;
  logic [W-2:0]        accel_time_o, cruise_time_o, decel_time_o;
  logic signed [W-1:0] open_loop_distance_o;

  profile_scoreboard sb = new();
  int burst_left = 0;

  trapezoid_velocity_profile_gen_core uut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("trapezoid_velocity_profile_gen_core regression: fail");
    $finish;
  end

  always @(posedge clk_i) begin
    motion_out_t r;
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_request(mode_i, target_distance_i, velocity_limit_i, accel_limit_i, time_step_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.vel = velocity_ref_o; r.ph = phase_e'(phase_o); r.done = profile_done_o;
      r.ta = accel_time_o; r.tc = cruise_time_o; r.td = decel_time_o;
      r.distance = open_loop_distance_o;
      sb.check_result(r);
    end
  end

  // receiver stalls: segments with their own stall probability
  initial begin
    int seg, pct;
    seg = 0; pct = 0;
    forever begin
      @(negedge clk_i);
      if (seg == 0) begin
        seg = $urandom_range(10, 200);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 60;
          default: pct = 95;
        endcase
      end
      seg--;
      out_ready_i <= ($urandom_range(0, 99) >= pct);
    end
  end

  task automatic send(bit mode, logic [W-1:0] tgt, logic [W-2:0] vl, logic [W-2:0] al,
                      logic [15:0] step);
    if (burst_left == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i <= 1;
    mode_i <= mode;
    target_distance_i <= tgt;
    velocity_limit_i <= vl;
    accel_limit_i <= al;
    time_step_i <= step;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    send(1'($urandom_range(0, 1)), $urandom, 31'($urandom), 31'($urandom),
         16'($urandom));
  endtask

  task automatic tick(logic [15:0] step);
    send(1, $urandom, 31'($urandom), 31'($urandom), step);
  endtask

  task automatic start(logic [W-1:0] tgt, logic [W-2:0] vl, logic [W-2:0] al);
    send(0, tgt, vl, al, 16'($urandom));
  endtask

  task automatic run_profile(output int n);
    int sz, ticks;
    logic [W-1:0] tgt;
    sz = $urandom_range(0, 9);
    tgt = (sz == 0) ? $urandom : $urandom_range(0, 20 << F);
    if ($urandom_range(0, 1)) tgt = -tgt;
    start(tgt, 31'($urandom_range(1 << 13, 4 << F)), 31'($urandom_range(1 << 14, 8 << F)));
    n = 1;
    ticks = $urandom_range(4, 40);
    repeat (ticks) begin
      if ($urandom_range(0, 19) == 0) tick(16'($urandom));
      else tick(16'($urandom_range(0, 16'h6000)));
      n++;
    end
  endtask

  initial begin
    int n, cnt;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    tick(16'h1000);
    start(32'h0004_0000, 31'h0001_0000, 31'h0001_0000);
    tick(16'h0000);
    tick(16'hFFFF);
    tick(16'h8000);
    tick(16'hFFFF);
    tick(16'hFFFF);
    tick(16'hFFFF);
    tick(16'hFFFF);
    start(32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    tick(16'hFFFF);
    start(32'h7FFF_FFFF, 31'h0000_0001, 31'h7FFF_FFFF);
    tick(16'h0001);
    start(32'h0001_0000, 31'h0001_0000, 31'h0);
    tick(16'h0100);
    start(32'hFFFF_0000, 31'h0, 31'h0001_0000);
    tick(16'hFFFF);
    start(32'h0001_0000, 31'h7FFF_FFFF, 31'h0000_0001);
    tick(16'hFFFF);
    start(32'h0, 31'h0001_0000, 31'h0001_0000);
    tick(16'h0001);
    tick(16'h0001);
    start(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    tick(16'hFFFF);
    tick(16'hFFFF);

    // hold off until the block has drained
    in_valid_i <= 0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);

    cnt = 0;
    while (cnt < 850) begin
      if ($urandom_range(0, 9) < 8) begin
        run_profile(n);
        cnt += n;
      end else begin
        send_noise();
        cnt++;
      end
    end
    in_valid_i <= 0;

    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("trapezoid_velocity_profile_gen_core regression: pass");
    else
      $display("trapezoid_velocity_profile_gen_core regression: fail");
    $finish;
  end

endmodule
